FILE: hw/rtl/rars_pkg.sv
`default_nettype none
package rars_pkg;

    // default sizing
    localparam int MAX_POSITIONS_DEF = 1024;
    localparam int NODE_COUNT_DEF    = 4096;

    // fixed field widths
    localparam int VAL_W    = 64;
    localparam int POS_IN_W = 11;
    localparam int CMD_W    = 2;

    // request command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_START,
        DP_CLR_WR,
        DP_RD,
        DP_TAG_V,
        DP_TAG_P,
        DP_MUL_HI,
        DP_WR_TAG,
        DP_WR_PZ,
        DP_ACC,
        DP_TMP_ZERO,
        DP_TMP_ADD,
        DP_WR_SUM
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic pend_zero;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/range_add_range_sum_tree.sv
// a clear request runs a clearing pass over every node; add and query requests walk the tree
// one request at a time, set by the single-port node memories
// reset: a clearing pass over all NODE_COUNT nodes runs with busy high
// the result strobe lasts one cycle; the receiver cannot stall
`default_nettype none
module range_add_range_sum_tree #(
    parameter int MAX_POSITIONS = rars_pkg::MAX_POSITIONS_DEF,
    parameter int NODE_COUNT    = rars_pkg::NODE_COUNT_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire [rars_pkg::CMD_W-1:0]            cmd,
    input  wire [rars_pkg::POS_IN_W-1:0]         left,
    input  wire [rars_pkg::POS_IN_W-1:0]         right,
    input  wire signed [rars_pkg::VAL_W-1:0]     value,
    output logic                                 done,
    output logic signed [rars_pkg::VAL_W-1:0]    range_sum,
    input  wire                                  cfg_we,
    input  wire [rars_pkg::POS_IN_W-1:0]         cfg_data
);
    import rars_pkg::*;

    dp_cmd_t                              dcmd;
    dp_stat_t                             dstat;
    logic [$clog2(NODE_COUNT)-1:0]        addr;
    logic [$clog2(MAX_POSITIONS+1)-1:0]   len;

    // sequencer
    rars_ctrl #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .NODE_COUNT    (NODE_COUNT)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .left     (left),
        .right    (right),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .dstat    (dstat),
        .busy     (busy),
        .done     (done),
        .dcmd     (dcmd),
        .addr     (addr),
        .len      (len)
    );

    // node stores and arithmetic
    rars_dpath #(
        .MAX_POSITIONS (MAX_POSITIONS),
        .NODE_COUNT    (NODE_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .dcmd      (dcmd),
        .addr      (addr),
        .len       (len),
        .value     (value),
        .dstat     (dstat),
        .range_sum (range_sum)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/rars_dpath.sv
`default_nettype none
module rars_dpath #(
    parameter int MAX_POSITIONS = rars_pkg::MAX_POSITIONS_DEF,
    parameter int NODE_COUNT    = rars_pkg::NODE_COUNT_DEF
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  rars_pkg::dp_cmd_t                          dcmd,
    input  wire [$clog2(NODE_COUNT)-1:0]               addr,
    input  wire [$clog2(MAX_POSITIONS+1)-1:0]          len,
    input  wire signed [rars_pkg::VAL_W-1:0]           value,
    output rars_pkg::dp_stat_t                         dstat,
    output logic signed [rars_pkg::VAL_W-1:0]          range_sum
);
    import rars_pkg::*;

    localparam int LEN_W = $clog2(MAX_POSITIONS + 1);

    logic [VAL_W-1:0] sum_mem  [NODE_COUNT];
    logic [VAL_W-1:0] pend_mem [NODE_COUNT];

    logic [VAL_W-1:0] rd_sum_reg, rd_pend_reg;
    logic [VAL_W-1:0] value_reg, tagv_reg, prod_reg, tmp_reg, acc_reg;

    logic             sum_we, pend_we, rd_en;
    logic [VAL_W-1:0] sum_wdata, pend_wdata;
    logic [LEN_W+31:0] mul_lo, mul_hi;

    // partial products of the node length times the tag
    assign mul_lo = len * tagv_reg[31:0];
    assign mul_hi = len * tagv_reg[63:32];

    // write port decode
    always_comb
    begin
        sum_we     = 1'b0;
        pend_we    = 1'b0;
        rd_en      = (dcmd.op == DP_RD);
        sum_wdata  = '0;
        pend_wdata = '0;
        case (dcmd.op)
            DP_CLR_WR:
            begin
                sum_we  = 1'b1;
                pend_we = 1'b1;
            end
            DP_WR_TAG:
            begin
                sum_we     = 1'b1;
                pend_we    = 1'b1;
                sum_wdata  = rd_sum_reg + prod_reg;
                pend_wdata = rd_pend_reg + tagv_reg;
            end
            DP_WR_PZ:
            begin
                pend_we = 1'b1;
            end
            DP_WR_SUM:
            begin
                sum_we    = 1'b1;
                sum_wdata = tmp_reg;
            end
            default:
            begin
                sum_we = 1'b0;
            end
        endcase
    end

    // node sum and pending tag stores
    always_ff @(posedge clk)
    begin
        if (sum_we)
            sum_mem[addr] <= sum_wdata;
        if (pend_we)
            pend_mem[addr] <= pend_wdata;
        if (rd_en)
        begin
            rd_sum_reg  <= sum_mem[addr];
            rd_pend_reg <= pend_mem[addr];
        end
    end

    // working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            case (dcmd.op)
                DP_START:
                begin
                    value_reg <= value;
                    acc_reg   <= '0;
                end
                DP_RD:       prod_reg <= 64'(mul_lo);
                DP_TAG_V:    tagv_reg <= value_reg;
                DP_TAG_P:    tagv_reg <= rd_pend_reg;
                DP_MUL_HI:   prod_reg <= prod_reg + {mul_hi[31:0], 32'd0};
                DP_ACC:      acc_reg  <= acc_reg + rd_sum_reg;
                DP_TMP_ZERO: tmp_reg  <= '0;
                DP_TMP_ADD:  tmp_reg  <= tmp_reg + rd_sum_reg;
                default:     tmp_reg  <= tmp_reg;
            endcase
        end
    end

    assign dstat.pend_zero = (rd_pend_reg == '0);
    assign range_sum       = acc_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/rars_ctrl.sv
`default_nettype none
module rars_ctrl #(
    parameter int MAX_POSITIONS = rars_pkg::MAX_POSITIONS_DEF,
    parameter int NODE_COUNT    = rars_pkg::NODE_COUNT_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                start,
    input  wire [rars_pkg::CMD_W-1:0]          cmd,
    input  wire [rars_pkg::POS_IN_W-1:0]       left,
    input  wire [rars_pkg::POS_IN_W-1:0]       right,
    input  wire                                cfg_we,
    input  wire [rars_pkg::POS_IN_W-1:0]       cfg_data,
    input  rars_pkg::dp_stat_t                 dstat,
    output logic                               busy,
    output logic                               done,
    output rars_pkg::dp_cmd_t                  dcmd,
    output logic [$clog2(NODE_COUNT)-1:0]      addr,
    output logic [$clog2(MAX_POSITIONS+1)-1:0] len
);
    import rars_pkg::*;

    localparam int ADDR_W = $clog2(NODE_COUNT);
    localparam int POS_W  = $clog2(MAX_POSITIONS + 1);
    localparam int CW     = (POS_W > POS_IN_W) ? POS_W : POS_IN_W;
    localparam int IDX_W  = $clog2(MAX_POSITIONS) + 2;
    localparam int STK_D  = $clog2(MAX_POSITIONS) + 1;
    localparam int SP_W   = $clog2(STK_D + 1);
    localparam int STI_W  = $clog2(STK_D);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_VISIT, S_COV_RD, S_COV_ACC, S_PD_RD, S_PD_CHK,
        S_PD_L, S_PD_R, S_TAG_RD, S_TAG_MHI, S_TAG_WR, S_PD_PZ, S_DESC,
        S_POP, S_REF_ZERO, S_REF_A_RD, S_REF_A_ADD, S_REF_B_RD, S_REF_B_ADD,
        S_REF_WR
    } state_t;

    typedef enum logic [1:0] {TR_COVER, TR_LEFT, TR_RIGHT} tag_ret_t;

    state_t               state_reg;
    tag_ret_t             tag_ret_reg;
    logic                 busy_reg, done_reg, clr_res_reg;
    logic [POS_W-1:0]     size_reg, size_next;
    logic [CMD_W-1:0]     cmd_reg;
    logic [POS_IN_W-1:0]  a_reg, b_reg;
    logic [IDX_W-1:0]     cur_u_reg, tgt_u_reg;
    logic [POS_W-1:0]     cur_lo_reg, cur_hi_reg, tgt_len_reg;
    logic [SP_W-1:0]      sp_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic [IDX_W-1:0]     stk_u   [STK_D];
    logic [POS_W-1:0]     stk_lo  [STK_D];
    logic [POS_W-1:0]     stk_hi  [STK_D];
    logic                 stk_rgt [STK_D];

    logic [IDX_W-1:0]     child_l, child_r, par_r;
    logic [POS_W-1:0]     mid, pmid;
    logic [STI_W-1:0]     top_i, push_i;
    logic                 skip, covered, accept;

    function automatic logic in_tree(input logic [IDX_W-1:0] n);
        return 32'(n) < 32'(NODE_COUNT);
    endfunction

    // register write clamps to the supported span
    always_comb
    begin
        if (cfg_data == '0)
            size_next = POS_W'(1);
        else if (32'(cfg_data) > 32'(MAX_POSITIONS))
            size_next = POS_W'(MAX_POSITIONS);
        else
            size_next = POS_W'(cfg_data);
    end

    // node geometry
    always_comb
    begin
        child_l = {cur_u_reg[IDX_W-2:0], 1'b0};
        child_r = {cur_u_reg[IDX_W-2:0], 1'b1};
        mid     = POS_W'(({1'b0, cur_lo_reg} + {1'b0, cur_hi_reg}) >> 1);
        top_i   = STI_W'(sp_reg - 1'b1);
        push_i  = STI_W'(sp_reg);
        par_r   = {stk_u[top_i][IDX_W-2:0], 1'b1};
        pmid    = POS_W'(({1'b0, stk_lo[top_i]} + {1'b0, stk_hi[top_i]}) >> 1);
        skip    = !in_tree(cur_u_reg) || (a_reg > b_reg)
                  || (CW'(a_reg) > CW'(cur_hi_reg)) || (CW'(b_reg) < CW'(cur_lo_reg));
        covered = (CW'(a_reg) <= CW'(cur_lo_reg)) && (CW'(cur_hi_reg) <= CW'(b_reg));
        accept  = start && !busy_reg && !cfg_we;
    end

    // datapath command decode
    always_comb
    begin
        dcmd.op = DP_NOP;
        addr    = ADDR_W'(cur_u_reg);
        case (state_reg)
            S_CLEAR:
            begin
                dcmd.op = DP_CLR_WR;
                addr    = clr_cnt_reg;
            end
            S_IDLE:      if (accept) dcmd.op = DP_START;
            S_VISIT:     if (!skip && covered && cmd_reg == CMD_ADD) dcmd.op = DP_TAG_V;
            S_COV_RD:    dcmd.op = DP_RD;
            S_PD_RD:     dcmd.op = DP_RD;
            S_COV_ACC:   dcmd.op = DP_ACC;
            S_PD_CHK:    if (!dstat.pend_zero) dcmd.op = DP_TAG_P;
            S_TAG_RD:
            begin
                dcmd.op = DP_RD;
                addr    = ADDR_W'(tgt_u_reg);
            end
            S_TAG_MHI:   dcmd.op = DP_MUL_HI;
            S_TAG_WR:
            begin
                dcmd.op = DP_WR_TAG;
                addr    = ADDR_W'(tgt_u_reg);
            end
            S_PD_PZ:     dcmd.op = DP_WR_PZ;
            S_REF_ZERO:  dcmd.op = DP_TMP_ZERO;
            S_REF_A_RD:
            begin
                dcmd.op = DP_RD;
                addr    = ADDR_W'(child_l);
            end
            S_REF_A_ADD: if (in_tree(child_l)) dcmd.op = DP_TMP_ADD;
            S_REF_B_RD:
            begin
                dcmd.op = DP_RD;
                addr    = ADDR_W'(child_r);
            end
            S_REF_B_ADD: if (in_tree(child_r)) dcmd.op = DP_TMP_ADD;
            S_REF_WR:    dcmd.op = DP_WR_SUM;
            default:     dcmd.op = DP_NOP;
        endcase
    end

    // sequencer: clearing pass, and tree walk with an explicit stack of parent nodes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
            clr_res_reg <= 1'b0;
            size_reg    <= POS_W'(MAX_POSITIONS);
            clr_cnt_reg <= '0;
            sp_reg      <= '0;
            tag_ret_reg <= TR_COVER;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
                size_reg <= size_next;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(NODE_COUNT - 1))
                    begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                        busy_reg    <= 1'b0;
                        done_reg    <= clr_res_reg;
                    end
                end
                S_IDLE:
                begin
                    if (cfg_we)
                    begin
                        state_reg   <= S_CLEAR;
                        busy_reg    <= 1'b1;
                        clr_res_reg <= 1'b0;
                    end
                    else if (start)
                    begin
                        cmd_reg <= cmd;
                        a_reg   <= left;
                        b_reg   <= right;
                        case (cmd)
                            CMD_CLEAR:
                            begin
                                state_reg   <= S_CLEAR;
                                busy_reg    <= 1'b1;
                                clr_res_reg <= 1'b1;
                            end
                            CMD_ADD, CMD_QUERY:
                            begin
                                cur_u_reg  <= IDX_W'(1);
                                cur_lo_reg <= POS_W'(1);
                                cur_hi_reg <= size_reg;
                                sp_reg     <= '0;
                                state_reg  <= S_VISIT;
                                busy_reg   <= 1'b1;
                            end
                            default:
                            begin
                                done_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_VISIT:
                begin
                    if (skip)
                        state_reg <= S_POP;
                    else if (covered)
                    begin
                        if (cmd_reg == CMD_ADD)
                        begin
                            tgt_u_reg   <= cur_u_reg;
                            tgt_len_reg <= cur_hi_reg - cur_lo_reg + 1'b1;
                            tag_ret_reg <= TR_COVER;
                            state_reg   <= S_TAG_RD;
                        end
                        else
                            state_reg <= S_COV_RD;
                    end
                    else
                        state_reg <= S_PD_RD;
                end
                S_COV_RD:  state_reg <= S_COV_ACC;
                S_COV_ACC: state_reg <= S_POP;
                S_PD_RD:   state_reg <= S_PD_CHK;
                S_PD_CHK:  state_reg <= dstat.pend_zero ? S_DESC : S_PD_L;
                S_PD_L:
                begin
                    if (in_tree(child_l))
                    begin
                        tgt_u_reg   <= child_l;
                        tgt_len_reg <= mid - cur_lo_reg + 1'b1;
                        tag_ret_reg <= TR_LEFT;
                        state_reg   <= S_TAG_RD;
                    end
                    else
                        state_reg <= S_PD_R;
                end
                S_PD_R:
                begin
                    if (in_tree(child_r))
                    begin
                        tgt_u_reg   <= child_r;
                        tgt_len_reg <= cur_hi_reg - mid;
                        tag_ret_reg <= TR_RIGHT;
                        state_reg   <= S_TAG_RD;
                    end
                    else
                        state_reg <= S_PD_PZ;
                end
                S_TAG_RD:  state_reg <= S_TAG_MHI;
                S_TAG_MHI: state_reg <= S_TAG_WR;
                S_TAG_WR:
                begin
                    case (tag_ret_reg)
                        TR_LEFT:  state_reg <= S_PD_R;
                        TR_RIGHT: state_reg <= S_PD_PZ;
                        default:  state_reg <= S_POP;
                    endcase
                end
                S_PD_PZ: state_reg <= S_DESC;
                S_DESC:
                begin
                    stk_u[push_i]   <= cur_u_reg;
                    stk_lo[push_i]  <= cur_lo_reg;
                    stk_hi[push_i]  <= cur_hi_reg;
                    stk_rgt[push_i] <= 1'b0;
                    sp_reg          <= sp_reg + 1'b1;
                    cur_u_reg       <= child_l;
                    cur_hi_reg      <= mid;
                    state_reg       <= S_VISIT;
                end
                S_POP:
                begin
                    if (sp_reg == '0)
                    begin
                        state_reg <= S_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    else if (!stk_rgt[top_i])
                    begin
                        stk_rgt[top_i] <= 1'b1;
                        cur_u_reg      <= par_r;
                        cur_lo_reg     <= pmid + 1'b1;
                        cur_hi_reg     <= stk_hi[top_i];
                        state_reg      <= S_VISIT;
                    end
                    else
                    begin
                        sp_reg    <= sp_reg - 1'b1;
                        cur_u_reg <= stk_u[top_i];
                        if (cmd_reg == CMD_ADD)
                            state_reg <= S_REF_ZERO;
                    end
                end
                S_REF_ZERO:  state_reg <= S_REF_A_RD;
                S_REF_A_RD:  state_reg <= S_REF_A_ADD;
                S_REF_A_ADD: state_reg <= S_REF_B_RD;
                S_REF_B_RD:  state_reg <= S_REF_B_ADD;
                S_REF_B_ADD: state_reg <= S_REF_WR;
                S_REF_WR:    state_reg <= S_POP;
                default:     state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign len  = tgt_len_reg;

    // checks
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("result strobe while still busy");
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= SP_W'(STK_D))
        else $error("walk stack overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy_reg || done_reg))
        else $error("accepted request neither started nor answered");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !busy_reg)
        else $error("busy while idle");

endmodule
`default_nettype wire
